>>> rtl/core/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared widths, constants and request types for the rgb to hsl converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int CH_W        = 8;
   localparam int OUT_W       = FRAC_BITS + 1;
   localparam int DIV_W       = 18;
   localparam int NUM_STAGES  = OUT_W;
   localparam int HUE_W       = 13;
   localparam int RED_WEIGHT  = 299;
   localparam int GRN_WEIGHT  = 587;
   localparam int BLU_WEIGHT  = 114;
   localparam int LUMA_DEN    = 255000;
   localparam int LIGHT_DEN   = 510;
   localparam int HALF_SUM    = 255;

   typedef struct packed {
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_op_type;

   typedef struct packed {
      div_op_type hue;
      div_op_type sat;
      div_op_type lig;
   } job_type;

endpackage

>>> rtl/core/rgb_to_hsl_converter.sv
// rsp_valid rises once a request has passed the front register, the queue and the divider stages
// throughput: one request per cycle, set by the 17-stage divider pipelines
// busy only rises if the two-entry queue fills, which the free-running back end prevents
// results cannot be held off; each stays on rsp_ for one cycle
// synchronous reset empties the pipeline and sets luma_mode to 0
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Converts 8-bit rgb pixels to hue, saturation and lightness in Q1.16.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [rgbhsl_pkg::CH_W-1:0]  req_red,
   input  logic [rgbhsl_pkg::CH_W-1:0]  req_green,
   input  logic [rgbhsl_pkg::CH_W-1:0]  req_blue,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   output logic                         rsp_valid,
   output logic [rgbhsl_pkg::OUT_W-1:0] rsp_hue,
   output logic [rgbhsl_pkg::OUT_W-1:0] rsp_saturation,
   output logic [rgbhsl_pkg::OUT_W-1:0] rsp_lightness
);
   import rgbhsl_pkg::*;

   logic    luma_mode_ff;
   logic    job_valid, head_valid, pop;
   job_type job, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         luma_mode_ff <= csr_wr_data;
      end
   end

   rgbhsl_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .luma_mode(luma_mode_ff), .job_valid(job_valid), .job(job)
   );

   rgbhsl_queue u_queue (
      .clock(clock), .reset(reset), .push(job_valid), .push_data(job),
      .pop(pop), .head_valid(head_valid), .head(head), .full(busy)
   );

   rgbhsl_back u_back (
      .clock(clock), .reset(reset), .head_valid(head_valid), .head(head),
      .pop(pop), .rsp_valid(rsp_valid), .rsp_hue(rsp_hue),
      .rsp_saturation(rsp_saturation), .rsp_lightness(rsp_lightness)
   );

endmodule

>>> rtl/core/rgbhsl_front.sv
// ----------------------------------------------------------------------------
// rgbhsl_front
// Takes a request, finds max and min and forms numerators and divisors.
// ----------------------------------------------------------------------------
module rgbhsl_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [rgbhsl_pkg::CH_W-1:0]  req_red,
   input  logic [rgbhsl_pkg::CH_W-1:0]  req_green,
   input  logic [rgbhsl_pkg::CH_W-1:0]  req_blue,
   input  logic                         luma_mode,
   output logic                         job_valid,
   output rgbhsl_pkg::job_type          job
);
   import rgbhsl_pkg::*;

   logic                    valid_ff, valid_in;
   job_type                 job_ff, job_in;
   logic [CH_W-1:0]         mx, mn, d;
   logic [CH_W:0]           s;
   logic [DIV_W-1:0]        lum_sum;
   logic signed [HUE_W-1:0] num, six_d, r_s, g_s, b_s, d_s;

   always_comb begin
      mx = req_red;
      mn = req_red;
      if (req_green > mx) mx = req_green;
      if (req_blue > mx) mx = req_blue;
      if (req_green < mn) mn = req_green;
      if (req_blue < mn) mn = req_blue;
      d = mx - mn;
      s = {1'b0, mx} + {1'b0, mn};

      r_s   = $signed(HUE_W'(req_red));
      g_s   = $signed(HUE_W'(req_green));
      b_s   = $signed(HUE_W'(req_blue));
      d_s   = $signed(HUE_W'(d));
      six_d = $signed(HUE_W'(6)) * d_s;
      // sector of the largest channel, red tested first
      if (req_red == mx) begin
         num = g_s - b_s;
      end else if (req_green == mx) begin
         num = (d_s <<< 1) + b_s - r_s;
      end else begin
         num = (d_s <<< 2) + r_s - g_s;
      end
      if (num < 0) num = num + six_d;
      if (num >= six_d) num = num - six_d;

      lum_sum = DIV_W'(RED_WEIGHT) * DIV_W'(req_red)
              + DIV_W'(GRN_WEIGHT) * DIV_W'(req_green)
              + DIV_W'(BLU_WEIGHT) * DIV_W'(req_blue);

      job_in = job_ff;
      if (d == '0) begin
         // gray pixel: hue and saturation come out as zero
         job_in.hue.num = '0;
         job_in.hue.den = DIV_W'(1);
         job_in.sat.num = '0;
         job_in.sat.den = DIV_W'(1);
      end else begin
         job_in.hue.num = DIV_W'(unsigned'(num));
         job_in.hue.den = DIV_W'(unsigned'(six_d));
         job_in.sat.num = DIV_W'(d);
         if (s < (CH_W+1)'(HALF_SUM)) begin
            job_in.sat.den = DIV_W'(s);
         end else begin
            job_in.sat.den = DIV_W'(LIGHT_DEN) - DIV_W'(s);
         end
      end
      if (luma_mode) begin
         job_in.lig.num = lum_sum;
         job_in.lig.den = DIV_W'(LUMA_DEN);
      end else begin
         job_in.lig.num = DIV_W'(s);
         job_in.lig.den = DIV_W'(LIGHT_DEN);
      end
      valid_in = start && !busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_in) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;

endmodule

>>> rtl/core/rgbhsl_queue.sv
// ----------------------------------------------------------------------------
// rgbhsl_queue
// Two-entry queue between the front and the divider pipeline.
// ----------------------------------------------------------------------------
module rgbhsl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rgbhsl_pkg::job_type push_data,
   input  logic                pop,
   output logic                head_valid,
   output rgbhsl_pkg::job_type head,
   output logic                full
);
   import rgbhsl_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != 2'd0);
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];
   assign full       = (count_ff == 2'd2);

endmodule

>>> rtl/core/rgbhsl_div.sv
// ----------------------------------------------------------------------------
// rgbhsl_div
// Pipelined restoring divider, one quotient bit per stage, num <= den.
// ----------------------------------------------------------------------------
module rgbhsl_div (
   input  logic                         clock,
   input  rgbhsl_pkg::div_op_type       op,
   output logic [rgbhsl_pkg::OUT_W-1:0] quo
);
   import rgbhsl_pkg::*;

   logic [DIV_W-1:0] rem_ff  [NUM_STAGES-1];
   logic [DIV_W-1:0] den_ff  [NUM_STAGES-1];
   logic [OUT_W-1:0] q_ff    [NUM_STAGES];
   logic [DIV_W:0]   trial   [NUM_STAGES];
   logic [DIV_W-1:0] den_cur [NUM_STAGES];
   logic             ge      [NUM_STAGES];

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_first
         // integer bit: no shift before the first trial
         assign trial[k]   = {1'b0, op.num};
         assign den_cur[k] = op.den;
         always_ff @(posedge clock) begin
            q_ff[k] <= OUT_W'(ge[k]);
         end
      end else begin : g_next
         assign trial[k]   = {rem_ff[k-1], 1'b0};
         assign den_cur[k] = den_ff[k-1];
         always_ff @(posedge clock) begin
            q_ff[k] <= {q_ff[k-1][OUT_W-2:0], ge[k]};
         end
      end
      assign ge[k] = (trial[k] >= {1'b0, den_cur[k]});
      if (k < NUM_STAGES - 1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[k] <= ge[k] ? DIV_W'(trial[k] - {1'b0, den_cur[k]}) : DIV_W'(trial[k]);
            den_ff[k] <= den_cur[k];
         end
      end
   end

   assign quo = q_ff[NUM_STAGES-1];

endmodule

>>> rtl/core/rgbhsl_back.sv
// ----------------------------------------------------------------------------
// rgbhsl_back
// Drains the queue into three divider pipelines and strobes out results.
// ----------------------------------------------------------------------------
module rgbhsl_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  rgbhsl_pkg::job_type          head,
   output logic                         pop,
   output logic                         rsp_valid,
   output logic [rgbhsl_pkg::OUT_W-1:0] rsp_hue,
   output logic [rgbhsl_pkg::OUT_W-1:0] rsp_saturation,
   output logic [rgbhsl_pkg::OUT_W-1:0] rsp_lightness
);
   import rgbhsl_pkg::*;

   logic [NUM_STAGES-1:0] vld_ff, vld_in;

   assign pop    = head_valid;
   assign vld_in = {vld_ff[NUM_STAGES-2:0], head_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   rgbhsl_div u_hue_div (.clock(clock), .op(head.hue), .quo(rsp_hue));
   rgbhsl_div u_sat_div (.clock(clock), .op(head.sat), .quo(rsp_saturation));
   rgbhsl_div u_lig_div (.clock(clock), .op(head.lig), .quo(rsp_lightness));

   assign rsp_valid = vld_ff[NUM_STAGES-1];

endmodule

>>> rtl/core/rgbhsl_checker.sv
// ----------------------------------------------------------------------------
// rgbhsl_checker
// Port-level checks on the rgb to hsl converter.
// ----------------------------------------------------------------------------
module rgbhsl_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic [rgbhsl_pkg::OUT_W-1:0] rsp_hue,
   input logic [rgbhsl_pkg::OUT_W-1:0] rsp_saturation,
   input logic [rgbhsl_pkg::OUT_W-1:0] rsp_lightness
);
   import rgbhsl_pkg::*;

   localparam logic [OUT_W-1:0] ONE_FX = OUT_W'(1) << FRAC_BITS;

   // each accepted request must be followed by a result on rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##19 rsp_valid)
      else $error("result missing after request");

   a_no_stall: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue < ONE_FX))
      else $error("hue out of range");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_saturation <= ONE_FX && rsp_lightness <= ONE_FX))
      else $error("saturation or lightness out of range");

endmodule

bind rgb_to_hsl_converter rgbhsl_checker u_rgbhsl_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_hue(rsp_hue),
   .rsp_saturation(rsp_saturation), .rsp_lightness(rsp_lightness)
);

>>> dv/rgb_to_hsl_converter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_checker
// Watches the request and result channels of the converter, works out the
// expected hue, saturation and lightness of each request and compares them.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [rgbhsl_pkg::CH_W-1:0]  req_red,
   input  logic [rgbhsl_pkg::CH_W-1:0]  req_green,
   input  logic [rgbhsl_pkg::CH_W-1:0]  req_blue,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         rsp_valid,
   input  logic [rgbhsl_pkg::OUT_W-1:0] rsp_hue,
   input  logic [rgbhsl_pkg::OUT_W-1:0] rsp_saturation,
   input  logic [rgbhsl_pkg::OUT_W-1:0] rsp_lightness,
   output int                           fail_count,
   output int                           pending_count,
   output int                           result_count
);
   import rgbhsl_pkg::*;

   typedef struct packed {
      logic [OUT_W-1:0] hue;
      logic [OUT_W-1:0] sat;
      logic [OUT_W-1:0] lig;
   } hsl_type;

   hsl_type hsl_queue[$];
   logic    luma_sel;

   // truncated quotient in q1.16
   function automatic logic [OUT_W-1:0] fix_quot(longint unsigned n, longint unsigned d);
      if (d == 0) return '0;
      return OUT_W'((n << FRAC_BITS) / d);
   endfunction

   function automatic hsl_type convert_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8,
                                             logic lm);
      longint r, g, b, mx, mn, d, s, num;
      hsl_type res;
      r = r8; g = g8; b = b8;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      s = mx + mn;
      res = '0;
      if (d != 0) begin
         res.sat = (s < HALF_SUM) ? fix_quot(d, s) : fix_quot(d, 2 * HALF_SUM - s);
         if (r == mx) num = g - b;
         else if (g == mx) num = 2 * d + b - r;
         else num = 4 * d + r - g;
         if (num < 0) num += 6 * d;
         if (num >= 6 * d) num -= 6 * d;
         res.hue = fix_quot(num, 6 * d);
      end
      if (lm)
         res.lig = fix_quot(RED_WEIGHT * r + GRN_WEIGHT * g + BLU_WEIGHT * b, LUMA_DEN);
      else
         res.lig = fix_quot(s, LIGHT_DEN);
      return res;
   endfunction

   assign pending_count = hsl_queue.size();

   always @(posedge clock) begin
      hsl_type exp_hsl;
      int      errs;
      errs = 0;
      if (reset) begin
         luma_sel     <= 1'b0;
         fail_count   <= 0;
         result_count <= 0;
         hsl_queue.delete();
      end else begin
         if (csr_wr_en) luma_sel <= csr_wr_data;
         if (start && !busy)
            hsl_queue.push_back(convert_pixel(req_red, req_green, req_blue, luma_sel));
         if (rsp_valid) begin
            result_count <= result_count + 1;
            if (hsl_queue.size() == 0) begin
               $error("result with no request waiting");
               errs++;
            end else begin
               exp_hsl = hsl_queue.pop_front();
               if (rsp_hue !== exp_hsl.hue) begin
                  $error("hue: expected %0d, got %0d", exp_hsl.hue, rsp_hue);
                  errs++;
               end
               if (rsp_saturation !== exp_hsl.sat) begin
                  $error("saturation: expected %0d, got %0d", exp_hsl.sat, rsp_saturation);
                  errs++;
               end
               if (rsp_lightness !== exp_hsl.lig) begin
                  $error("lightness: expected %0d, got %0d", exp_hsl.lig, rsp_lightness);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

>>> dv/rgb_to_hsl_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_test
// Drives directed and random pixels through the converter in both lightness
// modes, with and without random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_test;
   import rgbhsl_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   logic [CH_W-1:0] req_red, req_green, req_blue;
   logic            csr_wr_en, csr_wr_data;
   logic            rsp_valid;
   logic [OUT_W-1:0] rsp_hue, rsp_saturation, rsp_lightness;
   int              fail_count, pending_count, result_count;
   int              idle_cycles;
   int              pixel_count;

   rgb_to_hsl_converter i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_hue(rsp_hue),
      .rsp_saturation(rsp_saturation), .rsp_lightness(rsp_lightness)
   );

   rgb_to_hsl_converter_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_hue(rsp_hue),
      .rsp_saturation(rsp_saturation), .rsp_lightness(rsp_lightness),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // cycles with nothing accepted on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // one request; random gaps unless gaps_on is clear
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input bit gaps_on);
      while (gaps_on && $urandom_range(99, 0) < 13) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      // busy is settled by the falling edge and holds to the next rising edge
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      pixel_count++;
   endtask

   task automatic write_luma_mode(input logic lm);
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lm;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic directed_pixels();
      send_pixel(8'd0,   8'd0,   8'd0,   1);  // black
      send_pixel(8'd255, 8'd255, 8'd255, 1);  // white
      send_pixel(8'd128, 8'd128, 8'd128, 0);  // gray
      send_pixel(8'd255, 8'd0,   8'd0,   1);
      send_pixel(8'd0,   8'd255, 8'd0,   0);
      send_pixel(8'd0,   8'd0,   8'd255, 1);
      send_pixel(8'd255, 8'd0,   8'd1,   0);  // red max, hue wraps
      send_pixel(8'd255, 8'd255, 8'd0,   1);  // red and green tie
      send_pixel(8'd0,   8'd255, 8'd255, 0);  // green and blue tie
      send_pixel(8'd255, 8'd0,   8'd255, 1);  // red and blue tie
      send_pixel(8'd200, 8'd55,  8'd55,  0);  // max plus min exactly 255
      send_pixel(8'd200, 8'd54,  8'd54,  1);  // max plus min just below
      send_pixel(8'd255, 8'd254, 8'd254, 0);
      send_pixel(8'd1,   8'd0,   8'd0,   1);
      send_pixel(8'd170, 8'd85,  8'd85,  0);
   endtask

   task automatic random_pixels(input int n, input bit gaps_on);
      int kind;
      logic [7:0] a, c;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(9, 0);
         a = 8'($urandom); c = 8'($urandom);
         case (kind)
            0: send_pixel(a, a, a, gaps_on);  // gray
            1: send_pixel(a, a, c, gaps_on);
            2: send_pixel(c, a, a, gaps_on);
            3: send_pixel(a, 8'($urandom), 8'(255 - a), gaps_on);  // sum near threshold
            default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom), gaps_on);
         endcase
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_red     = '0;
      req_green   = '0;
      req_blue    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      pixel_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_pixels();
      random_pixels(300, 1);
      write_luma_mode(1'b1);
      directed_pixels();
      random_pixels(300, 1);
      random_pixels(150, 0);
      write_luma_mode(1'b0);
      random_pixels(250, 1);
      write_luma_mode(1'b1);
      random_pixels(250, 1);
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d pixels, checked %0d results across both lightness modes",
               pixel_count, result_count);
      if (fail_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
